/* rtl/fccl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fccl_pkg;

	localparam int NUM_CORNERS = 4;
	localparam int CIX_W = $clog2(NUM_CORNERS);
	localparam int W_W = 17;
	localparam int SUM_W = 19;
	localparam int V_W = 7;

	localparam logic [16:0] ONE = 17'h10000;
	localparam logic [16:0] PERC_KNEE = 17'((65536 + 9) / 10);
	localparam logic [16:0] ACT_MIN = 17'(65536 / 1000 + 1);
	localparam logic [6:0] VOICE_MAX = 7'd64;

	localparam int LANE_LAT = 18;
	localparam int DIV_LAT = 17;
	localparam int PIPE_LAT = 1 + LANE_LAT + 1 + DIV_LAT + 1;

	localparam logic [2:0] MODE_INSTANT = 3'd0;
	localparam logic [2:0] MODE_LINEAR = 3'd1;
	localparam logic [2:0] MODE_POWER = 3'd2;
	localparam logic [2:0] MODE_SMOOTH = 3'd3;
	localparam logic [2:0] MODE_EXP = 3'd4;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_PERC = 3'd1;
	localparam logic [2:0] REG_MORPH = 3'd2;
	localparam logic [2:0] REG_BUDGET = 3'd3;
	localparam logic [2:0] REG_LIM_A = 3'd4;
	localparam logic [2:0] REG_LIM_B = 3'd5;
	localparam logic [2:0] REG_LIM_C = 3'd6;
	localparam logic [2:0] REG_LIM_D = 3'd7;

	localparam logic [16:0] LOG2_TAB [17] = '{
		17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30110,
		17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49473, 17'd52911,
		17'd56229, 17'd59434, 17'd62535, 17'd65536
	};

	localparam logic [17:0] EXP2_TAB [17] = '{
		18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
		18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
		18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
	};

	typedef struct packed {
		logic [2:0]  mode;
		logic        perc;
		logic        hi;
		logic [18:0] e;
	} curve_ctl_t;

	typedef struct packed {
		logic [16:0] weight_a;
		logic [16:0] weight_b;
		logic [16:0] weight_c;
		logic [16:0] weight_d;
	} in_t;

	typedef struct packed {
		logic [16:0] level_a;
		logic [16:0] level_b;
		logic [16:0] level_c;
		logic [16:0] level_d;
		logic [6:0]  voices_a;
		logic [6:0]  voices_b;
		logic [6:0]  voices_c;
		logic [6:0]  voices_d;
		logic [8:0]  total_voices;
		logic [3:0]  active_mask;
	} out_t;

endpackage
`default_nettype wire

/* rtl/fccl_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module fccl_sqrt
	import fccl_pkg::*;
(
	input  logic        clk,
	input  logic [16:0] x,
	output logic [16:0] root
);

	localparam int STEPS = 17;

	logic [33:0] v_s [STEPS-1];
	logic [18:0] rem_s [STEPS];
	logic [16:0] root_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [33:0] v_in;
		logic [18:0] rem_in;
		logic [16:0] root_in;
		logic [20:0] cur;
		logic [20:0] trial;

		if (k == 0) begin : g_first
			assign v_in = {1'b0, x, 16'h0000};
			assign rem_in = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign cur = {rem_in, v_in[33-2*k -: 2]};
		assign trial = {2'b00, root_in, 2'b01};

		if (k < STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (cur >= trial) begin
				rem_s[k] <= 19'(cur - trial);
				root_s[k] <= {root_in[15:0], 1'b1};
			end else begin
				rem_s[k] <= cur[18:0];
				root_s[k] <= {root_in[15:0], 1'b0};
			end
		end
	end

	assign root = root_s[STEPS-1];

endmodule
`default_nettype wire

/* rtl/fccl_pow.sv */
`timescale 1ns / 1ps
`default_nettype none
module fccl_pow
	import fccl_pkg::*;
(
	input  logic        clk,
	input  logic [16:0] w,
	input  curve_ctl_t  ctl,
	output logic [16:0] r
);

	logic [16:0] xin;
	logic [3:0]  p;
	logic [15:0] y;
	logic [3:0]  lidx;
	logic [15:0] lrem;
	logic [12:0] ldif;

	logic [16:0] lb_s1;
	logic [28:0] lp_s1;
	logic [3:0]  p_s1;
	logic        zero_s1, full_s1, hi_s1;
	logic [18:0] e_s1;

	logic [16:0] lf;
	logic [20:0] neg;
	logic [39:0] m_s2;
	logic        zero_s2, full_s2, hi_s2;

	logic [23:0] q;
	logic [24:0] qc;
	logic [15:0] fr;
	logic [3:0]  eidx;
	logic [15:0] erem;
	logic [12:0] edif;
	logic [17:0] eb_s3;
	logic [28:0] ep_s3;
	logic [7:0]  c_s3;
	logic        zero_s3, full_s3, hi_s3;

	logic [17:0] ex;
	logic [17:0] sh;
	logic [16:0] pw;
	logic [16:0] r_s4;

	always_comb begin
		xin = ctl.hi ? ONE - w : w;
		p = '0;
		for (int b = 0; b < 16; b++) begin
			if (xin[b]) begin
				p = 4'(b);
			end
		end
		y = xin[15:0] << (4'd15 - p);
		lidx = y[14:11];
		lrem = {y[10:0], 5'b00000};
		ldif = 13'(LOG2_TAB[5'(lidx) + 5'd1] - LOG2_TAB[5'(lidx)]);
	end

	always_ff @(posedge clk) begin
		lb_s1 <= LOG2_TAB[5'(lidx)];
		lp_s1 <= 29'(ldif) * 29'(lrem);
		p_s1 <= p;
		zero_s1 <= (xin == '0);
		full_s1 <= xin[16];
		hi_s1 <= ctl.hi;
		e_s1 <= ctl.e;
	end

	always_comb begin
		lf = lb_s1 + 17'(lp_s1[28:16]);
		neg = {5'd16 - {1'b0, p_s1}, 16'h0000} - {4'b0000, lf};
	end

	always_ff @(posedge clk) begin
		m_s2 <= 40'(neg) * 40'(e_s1);
		zero_s2 <= zero_s1;
		full_s2 <= full_s1;
		hi_s2 <= hi_s1;
	end

	always_comb begin
		q = m_s2[39:16];
		qc = 25'(q) + 25'd65535;
		fr = ~q[15:0] + 16'd1;
		eidx = fr[15:12];
		erem = {fr[11:0], 4'b0000};
		edif = 13'(EXP2_TAB[5'(eidx) + 5'd1] - EXP2_TAB[5'(eidx)]);
	end

	always_ff @(posedge clk) begin
		eb_s3 <= EXP2_TAB[5'(eidx)];
		ep_s3 <= 29'(edif) * 29'(erem);
		c_s3 <= qc[23:16];
		zero_s3 <= zero_s2;
		full_s3 <= full_s2;
		hi_s3 <= hi_s2;
	end

	always_comb begin
		ex = eb_s3 + 18'(ep_s3[28:16]);
		sh = (c_s3 >= 8'd18) ? '0 : ex >> c_s3[4:0];
		if (zero_s3) begin
			pw = '0;
		end else if (full_s3 || sh > 18'(ONE)) begin
			pw = ONE;
		end else begin
			pw = sh[16:0];
		end
	end

	always_ff @(posedge clk) begin
		r_s4 <= hi_s3 ? ONE - pw : pw;
	end

	assign r = r_s4;

endmodule
`default_nettype wire

/* rtl/fccl_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
module fccl_lane
	import fccl_pkg::*;
(
	input  logic        clk,
	input  logic [16:0] w,
	input  logic        is_top,
	input  curve_ctl_t  ctl,
	output logic [16:0] lv
);

	localparam int DLY = LANE_LAT - 6;

	logic [33:0] sq_s1;
	logic [16:0] x_s1, x_s2, x_s3, x_s4;
	logic        top_s1, top_s2, top_s3, top_s4;
	logic [37:0] pm;
	logic [16:0] a_s2, perc_s2, perc_s3, perc_s4;
	logic [34:0] smp;
	logic [16:0] sm_s3, sm_s4;
	logic [16:0] ex_r;
	logic [16:0] root;
	logic [16:0] early_s5;
	logic [16:0] dly_s [DLY];
	logic [16:0] lv_s18;

	always_ff @(posedge clk) begin
		sq_s1 <= 34'(w) * 34'(w);
		x_s1 <= w;
		top_s1 <= is_top;
	end

	assign pm = {1'b0, sq_s1, 3'b000} + {3'b000, sq_s1, 1'b0};

	always_ff @(posedge clk) begin
		a_s2 <= sq_s1[32:16];
		perc_s2 <= (x_s1 < PERC_KNEE) ? 17'(pm[37:16]) : x_s1;
		x_s2 <= x_s1;
		top_s2 <= top_s1;
	end

	assign smp = 35'(a_s2) * 35'(18'(3 * 65536) - {x_s2, 1'b0});

	always_ff @(posedge clk) begin
		sm_s3 <= smp[32:16];
		perc_s3 <= perc_s2;
		x_s3 <= x_s2;
		top_s3 <= top_s2;
		sm_s4 <= sm_s3;
		perc_s4 <= perc_s3;
		x_s4 <= x_s3;
		top_s4 <= top_s3;
	end

	fccl_pow u_pow (
		.clk (clk),
		.w   (w),
		.ctl (ctl),
		.r   (ex_r)
	);

	fccl_sqrt u_sqrt (
		.clk  (clk),
		.x    (w),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (ctl.perc) begin
			early_s5 <= perc_s4;
		end else begin
			unique case (ctl.mode)
				MODE_INSTANT: early_s5 <= top_s4 ? ONE : '0;
				MODE_SMOOTH:  early_s5 <= sm_s4;
				MODE_EXP:     early_s5 <= ex_r;
				default:      early_s5 <= x_s4;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		dly_s[0] <= early_s5;
		for (int i = 1; i < DLY; i++) begin
			dly_s[i] <= dly_s[i-1];
		end
		lv_s18 <= (!ctl.perc && ctl.mode == MODE_POWER) ? root : dly_s[DLY-1];
	end

	assign lv = lv_s18;

endmodule
`default_nettype wire

/* rtl/fccl_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module fccl_div
	import fccl_pkg::*;
(
	input  logic             clk,
	input  logic [16:0]      num,
	input  logic [SUM_W-1:0] den,
	input  logic             zero,
	output logic [16:0]      quo
);

	localparam int RW = SUM_W + 1;

	logic [RW-1:0]    r_s [DIV_LAT];
	logic [16:0]      q_s [DIV_LAT];
	logic [SUM_W-1:0] d_s [DIV_LAT];
	logic             z_s [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_step
		logic [RW:0] cur;
		logic [16:0] q_in;
		logic [SUM_W-1:0] d_in;
		logic z_in;

		if (k == 0) begin : g_first
			assign cur = (RW+1)'(num);
			assign q_in = '0;
			assign d_in = den;
			assign z_in = zero;
		end else begin : g_next
			assign cur = {r_s[k-1], 1'b0};
			assign q_in = q_s[k-1];
			assign d_in = d_s[k-1];
			assign z_in = z_s[k-1];
		end

		always_ff @(posedge clk) begin
			d_s[k] <= d_in;
			z_s[k] <= z_in;
			if (cur >= (RW+1)'(d_in)) begin
				r_s[k] <= RW'(cur - (RW+1)'(d_in));
				q_s[k] <= {q_in[15:0], 1'b1};
			end else begin
				r_s[k] <= cur[RW-1:0];
				q_s[k] <= {q_in[15:0], 1'b0};
			end
		end
	end

	assign quo = z_s[DIV_LAT-1] ? '0 : q_s[DIV_LAT-1];

endmodule
`default_nettype wire

/* rtl/four_corner_crossfade_levels.sv */
// Throughput: one item per cycle; busy never rises, the four corner lanes
// and their 17-stage restoring dividers are fully pipelined.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset (arst_n low, asynchronous) clears the pipeline valid bits and loads
// register defaults: mode 2, perceptual on, morph 0.5, budget and limits 16.
`timescale 1ns / 1ps
`default_nettype none
module four_corner_crossfade_levels
	import fccl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  in_t         item,
	output logic        busy,
	output logic        done,
	output out_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0]  mode_q;
	logic        perc_q;
	logic [16:0] morph_q;
	logic [6:0]  budget_q;
	logic [6:0]  lim_q [NUM_CORNERS];

	logic        wr;
	curve_ctl_t  ctl;
	logic [16:0] s_sat, s_low;

	logic [16:0]      wraw [NUM_CORNERS];
	logic [16:0]      wsat [NUM_CORNERS];
	logic [CIX_W-1:0] tix;
	logic [16:0]      w_s1 [NUM_CORNERS];
	logic             top_s1 [NUM_CORNERS];
	logic [16:0]      lv [NUM_CORNERS];
	logic [16:0]      nl_s20 [NUM_CORNERS];
	logic [SUM_W-1:0] sum_s20;
	logic             zero_s20;
	logic [16:0]      quo [NUM_CORNERS];
	logic             vld_q [PIPE_LAT];

	logic [6:0]  budget;
	logic [6:0]  vc [NUM_CORNERS];
	logic [3:0]  act;
	logic [8:0]  total;
	out_t        res_q;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_POWER;
			perc_q <= 1'b1;
			morph_q <= 17'd32768;
			budget_q <= 7'd16;
			for (int i = 0; i < NUM_CORNERS; i++) begin
				lim_q[i] <= 7'd16;
			end
		end else if (wr) begin
			unique case (paddr[4:2])
				REG_MODE:   mode_q <= pwdata[2:0];
				REG_PERC:   perc_q <= pwdata[0];
				REG_MORPH:  morph_q <= pwdata[16:0];
				REG_BUDGET: budget_q <= pwdata[6:0];
				REG_LIM_A:  lim_q[0] <= pwdata[6:0];
				REG_LIM_B:  lim_q[1] <= pwdata[6:0];
				REG_LIM_C:  lim_q[2] <= pwdata[6:0];
				REG_LIM_D:  lim_q[3] <= pwdata[6:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_MODE:   prdata = 32'(mode_q);
			REG_PERC:   prdata = 32'(perc_q);
			REG_MORPH:  prdata = 32'(morph_q);
			REG_BUDGET: prdata = 32'(budget_q);
			REG_LIM_A:  prdata = 32'(lim_q[0]);
			REG_LIM_B:  prdata = 32'(lim_q[1]);
			REG_LIM_C:  prdata = 32'(lim_q[2]);
			REG_LIM_D:  prdata = 32'(lim_q[3]);
		endcase
	end

	always_comb begin
		s_sat = (morph_q > ONE) ? ONE : morph_q;
		ctl.hi = s_sat[16] | s_sat[15];
		s_low = ctl.hi ? s_sat - 17'd32768 : s_sat;
		ctl.e = 19'(ONE) + 19'({s_low, 3'b000});
		ctl.mode = mode_q;
		ctl.perc = perc_q;
	end

	assign wraw[0] = item.weight_a;
	assign wraw[1] = item.weight_b;
	assign wraw[2] = item.weight_c;
	assign wraw[3] = item.weight_d;

	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			wsat[i] = (wraw[i] > ONE) ? ONE : wraw[i];
		end
		tix = '0;
		for (int i = 1; i < NUM_CORNERS; i++) begin
			if (wsat[i] > wsat[tix]) begin
				tix = CIX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			w_s1[i] <= wsat[i];
			top_s1[i] <= (tix == CIX_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i < PIPE_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	for (genvar g = 0; g < NUM_CORNERS; g++) begin : g_lane
		fccl_lane u_lane (
			.clk    (clk),
			.w      (w_s1[g]),
			.is_top (top_s1[g]),
			.ctl    (ctl),
			.lv     (lv[g])
		);

		fccl_div u_div (
			.clk  (clk),
			.num  (nl_s20[g]),
			.den  (sum_s20),
			.zero (zero_s20),
			.quo  (quo[g])
		);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			nl_s20[i] <= lv[i];
		end
		sum_s20 <= SUM_W'(lv[0]) + SUM_W'(lv[1]) + SUM_W'(lv[2]) + SUM_W'(lv[3]);
		zero_s20 <= (lv[0] == '0) && (lv[1] == '0) && (lv[2] == '0) && (lv[3] == '0);
	end

	always_comb begin
		logic [23:0] prod;
		logic [7:0]  raw;
		logic [6:0]  lim;
		budget = (budget_q > VOICE_MAX) ? VOICE_MAX : budget_q;
		total = '0;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			lim = (lim_q[i] > VOICE_MAX) ? VOICE_MAX : lim_q[i];
			prod = 24'(quo[i]) * 24'(budget);
			raw = prod[23:16];
			act[i] = (quo[i] >= ACT_MIN);
			if (!act[i]) begin
				vc[i] = '0;
			end else if (raw > 8'(lim)) begin
				vc[i] = lim;
			end else begin
				vc[i] = raw[6:0];
			end
			total = total + 9'(vc[i]);
		end
	end

	always_ff @(posedge clk) begin
		res_q.level_a <= quo[0];
		res_q.level_b <= quo[1];
		res_q.level_c <= quo[2];
		res_q.level_d <= quo[3];
		res_q.voices_a <= vc[0];
		res_q.voices_b <= vc[1];
		res_q.voices_c <= vc[2];
		res_q.voices_d <= vc[3];
		res_q.total_voices <= total;
		res_q.active_mask <= act;
	end

	assign result = res_q;
	assign done = vld_q[PIPE_LAT-1];

	ap_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LAT done)
		else $error("transfer without result at fixed latency");

	ap_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.total_voices == 9'(result.voices_a) + 9'(result.voices_b)
			+ 9'(result.voices_c) + 9'(result.voices_d))
		else $error("voice total mismatch");

	ap_idle_a: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.active_mask[0] |-> result.voices_a == 7'd0)
		else $error("inactive corner holds voices");

endmodule
`default_nettype wire
